FILE: design/tri2d_pkg.sv
// ----------------------------------------------------------------------------
// tri2d_pkg
// Shared types and constants for the three-anchor 2D position solver.
// ----------------------------------------------------------------------------
package tri2d_pkg;

    localparam int QBITS = 32;

    typedef struct packed {
        logic det_zero;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } t_flags;

endpackage

FILE: design/trilateration_2d_top.sv
// ----------------------------------------------------------------------------
// trilateration_2d_top
// Position from three anchors and ranges by Cramer's rule, rounded to
// nearest with ties away from zero and saturated to 32 bits.
// Pipeline of 6 front stages, 32 divider cells and 1 output register.
// Throughput: one beat per cycle while the receiver does not stall.
// Synchronous active-low reset clears all valid flags; data is not reset.
// ----------------------------------------------------------------------------
module trilateration_2d_top #(
    parameter int COORD_BITS = 21
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // a0_x, a0_y, a0_range, a1_x, a1_y, a1_range, a2_x, a2_y, a2_range
    input  logic [((9*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // pos_x, pos_y
    output logic [63:0]                           m_axis_tdata,
    // fix_valid, clipped
    output logic [1:0]                            m_axis_tuser
);
    import tri2d_pkg::*;

    localparam int D2W   = 2 * COORD_BITS + 4;
    localparam int REM_W = D2W + 1;
    localparam logic [QBITS-1:0] POS_MAX = {1'b0, {(QBITS-1){1'b1}}};
    localparam logic [QBITS-1:0] NEG_MAX = {1'b1, {(QBITS-1){1'b0}}};

    logic             c_v   [QBITS+1];
    logic             c_rdy [QBITS+1];
    t_flags           c_fl  [QBITS+1];
    logic [QBITS-1:0] c_nx  [QBITS+1];
    logic [QBITS-1:0] c_ny  [QBITS+1];
    logic [QBITS-1:0] c_qx  [QBITS+1];
    logic [QBITS-1:0] c_qy  [QBITS+1];
    logic [REM_W-1:0] c_rx  [QBITS+1];
    logic [REM_W-1:0] c_ry  [QBITS+1];
    logic [D2W-1:0]   c_den [QBITS+1];

    tri2d_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata[9*COORD_BITS-1:0]),
        .o_valid (c_v[0]),
        .i_ready (c_rdy[0]),
        .o_flags (c_fl[0]),
        .o_num_x (c_nx[0]),
        .o_num_y (c_ny[0]),
        .o_rem_x (c_rx[0]),
        .o_rem_y (c_ry[0]),
        .o_den   (c_den[0])
    );

    assign c_qx[0] = '0;
    assign c_qy[0] = '0;

    for (genvar j = 0; j < QBITS; j++) begin : g_cell
        tri2d_div_cell #(
            .REM_W(REM_W),
            .BIT  (QBITS - 1 - j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_v[j]),
            .o_ready (c_rdy[j]),
            .i_flags (c_fl[j]),
            .i_num_x (c_nx[j]),
            .i_num_y (c_ny[j]),
            .i_q_x   (c_qx[j]),
            .i_q_y   (c_qy[j]),
            .i_rem_x (c_rx[j]),
            .i_rem_y (c_ry[j]),
            .i_den   (c_den[j]),
            .o_valid (c_v[j+1]),
            .i_ready (c_rdy[j+1]),
            .o_flags (c_fl[j+1]),
            .o_num_x (c_nx[j+1]),
            .o_num_y (c_ny[j+1]),
            .o_q_x   (c_qx[j+1]),
            .o_q_y   (c_qy[j+1]),
            .o_rem_x (c_rx[j+1]),
            .o_rem_y (c_ry[j+1]),
            .o_den   (c_den[j+1])
        );
    end

    logic             r_ov;
    logic             out_rdy;
    t_flags           fl;
    logic [QBITS-1:0] qx, qy, px, py;
    logic             clip_x, clip_y;

    assign fl = c_fl[QBITS];
    assign qx = c_qx[QBITS];
    assign qy = c_qy[QBITS];

    always_comb begin
        if (fl.neg_x) begin
            clip_x = fl.ovf_x || (qx > NEG_MAX);
            px     = clip_x ? NEG_MAX : QBITS'(-qx);
        end else begin
            clip_x = fl.ovf_x || qx[QBITS-1];
            px     = clip_x ? POS_MAX : qx;
        end
        if (fl.neg_y) begin
            clip_y = fl.ovf_y || (qy > NEG_MAX);
            py     = clip_y ? NEG_MAX : QBITS'(-qy);
        end else begin
            clip_y = fl.ovf_y || qy[QBITS-1];
            py     = clip_y ? POS_MAX : qy;
        end
    end

    assign out_rdy       = !r_ov || m_axis_tready;
    assign c_rdy[QBITS]  = out_rdy;
    assign m_axis_tvalid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_rdy) begin
            r_ov <= c_v[QBITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy) begin
            if (fl.det_zero) begin
                m_axis_tdata <= '0;
                m_axis_tuser <= '0;
            end else begin
                m_axis_tdata <= {py, px};
                m_axis_tuser <= {clip_x || clip_y, 1'b1};
            end
        end
    end

endmodule

FILE: design/tri2d_front.sv
// ----------------------------------------------------------------------------
// tri2d_front
// Six-stage pipeline: squares and differences, linear system terms, Cramer
// numerators and determinant, then the operands of the rounding divider.
// ----------------------------------------------------------------------------
module tri2d_front #(
    parameter int COORD_BITS = 21
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [9*COORD_BITS-1:0]               i_data,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output tri2d_pkg::t_flags                     o_flags,
    output logic [tri2d_pkg::QBITS-1:0]           o_num_x,
    output logic [tri2d_pkg::QBITS-1:0]           o_num_y,
    output logic [2*COORD_BITS+4:0]               o_rem_x,
    output logic [2*COORD_BITS+4:0]               o_rem_y,
    output logic [2*COORD_BITS+3:0]               o_den
);
    import tri2d_pkg::*;

    localparam int N      = COORD_BITS;
    localparam int DIFF_W = N + 1;
    localparam int SQ_W   = 2 * N + 1;
    localparam int E_W    = 2 * N + 3;
    localparam int LB     = N + 2;
    localparam int EH_W   = E_W - LB;
    localparam int PL_W   = LB + 1 + DIFF_W;
    localparam int PH_W   = EH_W + DIFF_W;
    localparam int AD_W   = 2 * DIFF_W;
    localparam int DET_W  = 2 * N + 3;
    localparam int NUM_W  = 3 * N + 4;
    localparam int N2W    = 3 * N + 5;
    localparam int D2W    = 2 * N + 4;
    localparam int REM_W  = D2W + 1;
    localparam int HI_W   = N2W - QBITS;
    localparam int CW     = (HI_W > D2W) ? HI_W : D2W;

    function automatic logic signed [SQ_W-1:0] sq(input logic signed [N:0] v);
        logic signed [2*N+1:0] p;
        p = v * v;
        return p[SQ_W-1:0];
    endfunction

    function automatic logic signed [E_W-1:0] ext_e(input logic signed [SQ_W-1:0] v);
        return {{(E_W-SQ_W){v[SQ_W-1]}}, v};
    endfunction

    function automatic logic signed [NUM_W-1:0] ext_pl(input logic signed [PL_W-1:0] v);
        return {{(NUM_W-PL_W){v[PL_W-1]}}, v};
    endfunction

    function automatic logic signed [NUM_W-1:0] ext_ph(input logic signed [PH_W-1:0] v);
        logic signed [NUM_W-1:0] t;
        t = {{(NUM_W-PH_W){v[PH_W-1]}}, v};
        return t <<< LB;
    endfunction

    logic [7:1] rdy;
    logic [6:1] r_v;

    logic signed [N:0] x0, y0, r0, x1, y1, r1, x2, y2, r2;

    assign x0 = {i_data[0*N+N-1], i_data[0*N +: N]};
    assign y0 = {i_data[1*N+N-1], i_data[1*N +: N]};
    assign r0 = {1'b0, i_data[2*N +: N]};
    assign x1 = {i_data[3*N+N-1], i_data[3*N +: N]};
    assign y1 = {i_data[4*N+N-1], i_data[4*N +: N]};
    assign r1 = {1'b0, i_data[5*N +: N]};
    assign x2 = {i_data[6*N+N-1], i_data[6*N +: N]};
    assign y2 = {i_data[7*N+N-1], i_data[7*N +: N]};
    assign r2 = {1'b0, i_data[8*N +: N]};

    always_comb begin
        rdy[7] = i_ready;
        for (int k = 6; k >= 1; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_ready = rdy[1];
    assign o_valid = r_v[6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= 6; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1
    logic signed [DIFF_W-1:0] r1_a, r1_b, r1_c, r1_d;
    logic signed [SQ_W-1:0]   r1_sx0, r1_sy0, r1_sr0, r1_sx1, r1_sy1, r1_sr1;
    logic signed [SQ_W-1:0]   r1_sx2, r1_sy2, r1_sr2;

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_a   <= x1 - x0;
            r1_b   <= y1 - y0;
            r1_c   <= x2 - x0;
            r1_d   <= y2 - y0;
            r1_sx0 <= sq(x0);
            r1_sy0 <= sq(y0);
            r1_sr0 <= sq(r0);
            r1_sx1 <= sq(x1);
            r1_sy1 <= sq(y1);
            r1_sr1 <= sq(r1);
            r1_sx2 <= sq(x2);
            r1_sy2 <= sq(y2);
            r1_sr2 <= sq(r2);
        end
    end

    // stage 2
    logic signed [DIFF_W-1:0] r2_a, r2_b, r2_c, r2_d;
    logic signed [E_W-1:0]    r2_e, r2_f;
    logic signed [AD_W-1:0]   r2_ad, r2_bc;
    logic signed [E_W-1:0]    base;

    assign base = ext_e(r1_sr0) - ext_e(r1_sx0) - ext_e(r1_sy0);

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r2_a  <= r1_a;
            r2_b  <= r1_b;
            r2_c  <= r1_c;
            r2_d  <= r1_d;
            r2_e  <= base - ext_e(r1_sr1) + ext_e(r1_sx1) + ext_e(r1_sy1);
            r2_f  <= base - ext_e(r1_sr2) + ext_e(r1_sx2) + ext_e(r1_sy2);
            r2_ad <= r1_a * r1_d;
            r2_bc <= r1_b * r1_c;
        end
    end

    // stage 3
    logic signed [LB:0]       el, fl;
    logic signed [EH_W-1:0]   eh, fh;
    logic signed [PL_W-1:0]   r3_eld, r3_flb, r3_fla, r3_elc;
    logic signed [PH_W-1:0]   r3_ehd, r3_fhb, r3_fha, r3_ehc;
    logic signed [DET_W-1:0]  r3_det;

    assign el = {1'b0, r2_e[LB-1:0]};
    assign fl = {1'b0, r2_f[LB-1:0]};
    assign eh = r2_e[E_W-1:LB];
    assign fh = r2_f[E_W-1:LB];

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r3_det <= {r2_ad[AD_W-1], r2_ad} - {r2_bc[AD_W-1], r2_bc};
            r3_eld <= el * r2_d;
            r3_ehd <= eh * r2_d;
            r3_flb <= fl * r2_b;
            r3_fhb <= fh * r2_b;
            r3_fla <= fl * r2_a;
            r3_fha <= fh * r2_a;
            r3_elc <= el * r2_c;
            r3_ehc <= eh * r2_c;
        end
    end

    // stage 4
    logic signed [NUM_W-1:0] r4_nx, r4_ny;
    logic signed [DET_W-1:0] r4_det;

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r4_det <= r3_det;
            r4_nx  <= ext_ph(r3_ehd) + ext_pl(r3_eld) - ext_ph(r3_fhb) - ext_pl(r3_flb);
            r4_ny  <= ext_ph(r3_fha) + ext_pl(r3_fla) - ext_ph(r3_ehc) - ext_pl(r3_elc);
        end
    end

    // stage 5
    logic [NUM_W-1:0]   abs_nx, abs_ny;
    logic [DET_W-1:0]   abs_det;
    logic [N2W-1:0]     m_ext;
    logic [N2W-1:0]     r5_n2x, r5_n2y;
    logic [D2W-1:0]     r5_d2;
    t_flags             r5_flags;

    assign abs_nx  = r4_nx[NUM_W-1] ? NUM_W'(-r4_nx) : r4_nx;
    assign abs_ny  = r4_ny[NUM_W-1] ? NUM_W'(-r4_ny) : r4_ny;
    assign abs_det = r4_det[DET_W-1] ? DET_W'(-r4_det) : r4_det;
    assign m_ext   = N2W'({abs_det[DET_W-2:0], 1'b0});

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r5_n2x            <= {abs_nx, 1'b0} + m_ext;
            r5_n2y            <= {abs_ny, 1'b0} + m_ext;
            r5_d2             <= {abs_det[DET_W-2:0], 2'b00};
            r5_flags.det_zero <= (r4_det == '0);
            r5_flags.neg_x    <= r4_nx[NUM_W-1] ^ r4_det[DET_W-1];
            r5_flags.neg_y    <= r4_ny[NUM_W-1] ^ r4_det[DET_W-1];
            r5_flags.ovf_x    <= 1'b0;
            r5_flags.ovf_y    <= 1'b0;
        end
    end

    // stage 6
    logic [HI_W-1:0] hix, hiy;
    t_flags          n_flags;

    assign hix = r5_n2x[N2W-1:QBITS];
    assign hiy = r5_n2y[N2W-1:QBITS];

    always_comb begin
        n_flags       = r5_flags;
        n_flags.ovf_x = CW'(hix) >= CW'(r5_d2);
        n_flags.ovf_y = CW'(hiy) >= CW'(r5_d2);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            o_flags       <= n_flags;
            o_num_x       <= r5_n2x[QBITS-1:0];
            o_num_y       <= r5_n2y[QBITS-1:0];
            o_rem_x       <= REM_W'(hix);
            o_rem_y       <= REM_W'(hiy);
            o_den         <= r5_d2;
        end
    end

endmodule

FILE: design/tri2d_div_cell.sv
// ----------------------------------------------------------------------------
// tri2d_div_cell
// One restoring division step for both coordinates: shift in one numerator
// bit, compare and subtract, set one quotient bit.
// ----------------------------------------------------------------------------
module tri2d_div_cell #(
    parameter int REM_W = 47,
    parameter int BIT   = 31
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  tri2d_pkg::t_flags                 i_flags,
    input  logic [tri2d_pkg::QBITS-1:0]       i_num_x,
    input  logic [tri2d_pkg::QBITS-1:0]       i_num_y,
    input  logic [tri2d_pkg::QBITS-1:0]       i_q_x,
    input  logic [tri2d_pkg::QBITS-1:0]       i_q_y,
    input  logic [REM_W-1:0]                  i_rem_x,
    input  logic [REM_W-1:0]                  i_rem_y,
    input  logic [REM_W-2:0]                  i_den,
    output logic                              o_valid,
    input  logic                              i_ready,
    output tri2d_pkg::t_flags                 o_flags,
    output logic [tri2d_pkg::QBITS-1:0]       o_num_x,
    output logic [tri2d_pkg::QBITS-1:0]       o_num_y,
    output logic [tri2d_pkg::QBITS-1:0]       o_q_x,
    output logic [tri2d_pkg::QBITS-1:0]       o_q_y,
    output logic [REM_W-1:0]                  o_rem_x,
    output logic [REM_W-1:0]                  o_rem_y,
    output logic [REM_W-2:0]                  o_den
);
    import tri2d_pkg::*;

    logic             r_v;
    logic [REM_W-1:0] sh_x, sh_y, den_e;
    logic             ge_x, ge_y;
    logic [QBITS-1:0] n_q_x, n_q_y;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;

    assign den_e = {1'b0, i_den};
    assign sh_x  = {i_rem_x[REM_W-2:0], i_num_x[BIT]};
    assign sh_y  = {i_rem_y[REM_W-2:0], i_num_y[BIT]};
    assign ge_x  = sh_x >= den_e;
    assign ge_y  = sh_y >= den_e;

    always_comb begin
        n_q_x      = i_q_x;
        n_q_y      = i_q_y;
        n_q_x[BIT] = ge_x;
        n_q_y[BIT] = ge_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            o_flags <= i_flags;
            o_num_x <= i_num_x;
            o_num_y <= i_num_y;
            o_q_x   <= n_q_x;
            o_q_y   <= n_q_y;
            o_rem_x <= ge_x ? sh_x - den_e : sh_x;
            o_rem_y <= ge_y ? sh_y - den_e : sh_y;
            o_den   <= i_den;
        end
    end

endmodule

FILE: tb/trilateration_2d_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trilateration_2d_top_tb
// Drives random and corner-case anchor sets into the position solver and
// checks every output beat against a 128-bit integer Cramer's rule solution.
// ----------------------------------------------------------------------------
module trilateration_2d_top_tb;

    localparam int CB = 21;
    localparam int DW = ((9*CB+7)/8)*8;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic        fix_valid;
        logic        clipped;
    } t_fix;

    class fix_board;
        t_fix pending[$];
        int   errors;

        function automatic logic [31:0] round_sat(logic signed [127:0] num,
                                                  logic signed [127:0] den,
                                                  ref logic clip);
            logic        neg;
            logic [127:0] n, m, q;
            neg = num[127] ^ den[127];
            n = num[127] ? -num : num;
            m = den[127] ? -den : den;
            q = ((n << 1) + m) / (m << 1);
            if (neg) begin
                if (q > 128'h8000_0000) begin
                    clip = 1'b1;
                    return 32'h8000_0000;
                end
                return -q[31:0];
            end
            if (q > 128'h7FFF_FFFF) begin
                clip = 1'b1;
                return 32'h7FFF_FFFF;
            end
            return q[31:0];
        endfunction

        function void note_anchors(logic [DW-1:0] d);
            logic signed [127:0] x0, y0, r0, x1, y1, r1, x2, y2, r2;
            logic signed [127:0] a, b, c, dd, e, f, base, det;
            logic                clip;
            t_fix                fx;
            x0 = $signed(d[0*CB +: CB]);   y0 = $signed(d[1*CB +: CB]);
            r0 = {107'd0, d[2*CB +: CB]};
            x1 = $signed(d[3*CB +: CB]);   y1 = $signed(d[4*CB +: CB]);
            r1 = {107'd0, d[5*CB +: CB]};
            x2 = $signed(d[6*CB +: CB]);   y2 = $signed(d[7*CB +: CB]);
            r2 = {107'd0, d[8*CB +: CB]};
            a = x1 - x0; b = y1 - y0; c = x2 - x0; dd = y2 - y0;
            base = r0*r0 - x0*x0 - y0*y0;
            e = base - r1*r1 + x1*x1 + y1*y1;
            f = base - r2*r2 + x2*x2 + y2*y2;
            det = a*dd - b*c;
            fx = '0;
            clip = 1'b0;
            if (det != 0) begin
                fx.pos_x = round_sat(e*dd - f*b, det <<< 1, clip);
                fx.pos_y = round_sat(a*f - c*e, det <<< 1, clip);
                fx.fix_valid = 1'b1;
                fx.clipped = clip;
            end
            pending.push_back(fx);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_fix(logic [63:0] data, logic [1:0] user);
            t_fix w;
            if (pending.size() == 0) begin
                report("output beat with nothing pending");
                return;
            end
            w = pending.pop_front();
            if (data[31:0] !== w.pos_x)
                report($sformatf("pos_x %h want %h", data[31:0], w.pos_x));
            if (data[63:32] !== w.pos_y)
                report($sformatf("pos_y %h want %h", data[63:32], w.pos_y));
            if (user[0] !== w.fix_valid)
                report($sformatf("fix_valid %b want %b", user[0], w.fix_valid));
            if (user[1] !== w.clipped)
                report($sformatf("clipped %b want %b", user[1], w.clipped));
        endtask
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [63:0]   m_axis_tdata;
    logic [1:0]    m_axis_tuser;

    fix_board board = new();
    int       cycles = 0;
    bit       hold_off = 1'b0;

    always #10 i_clk = ~i_clk;

    trilateration_2d_top #(.COORD_BITS(CB)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            board.note_anchors(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_fix(m_axis_tdata, m_axis_tuser);
    end

    // receiver stall pattern
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (hold_off)
                m_axis_tready <= 1'b0;
            else if ((phase / 64) % 3 == 0)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    function automatic logic [CB-1:0] pick_coord(int mode);
        case (mode)
            0: return {1'b1, {(CB-1){1'b0}}};
            1: return {1'b0, {(CB-1){1'b1}}};
            2: return CB'($urandom_range(0, 2000)) - CB'(1000);
            default: return CB'($urandom);
        endcase
    endfunction

    function automatic logic [DW-1:0] random_anchors();
        logic [DW-1:0] d;
        int            mode;
        d = '0;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++) begin
            if (mode < 2)
                d[k*CB +: CB] = pick_coord($urandom_range(0, 3));
            else if (mode < 5)
                d[k*CB +: CB] = pick_coord(2);
            else
                d[k*CB +: CB] = CB'($urandom);
        end
        // coincident anchors or a shared x coordinate now and then
        if (mode == 9) begin
            d[6*CB +: CB] = d[3*CB +: CB];
            d[7*CB +: CB] = d[4*CB +: CB];
        end else if (mode == 8) begin
            d[3*CB +: CB] = d[0*CB +: CB];
        end
        if (mode == 7)
            d[DW-1 -: (DW-9*CB)] = '1;
        return d;
    endfunction

    task send_beat(logic [DW-1:0] d);
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task go_idle(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [DW-1:0] d;
        int            burst;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, zero determinant, clipping, rounding ties
        send_beat('0);
        d = '0;
        for (int k = 0; k < 9; k++) d[k*CB +: CB] = pick_coord(0);
        send_beat(d);
        for (int k = 0; k < 9; k++) d[k*CB +: CB] = pick_coord(1);
        send_beat(d);
        send_beat('1);
        d = '0;
        d[3*CB +: CB] = CB'(2); d[7*CB +: CB] = CB'(2); d[2*CB +: CB] = CB'(1);
        send_beat(d);
        d[2*CB +: CB] = CB'(3); d[5*CB +: CB] = CB'(2);
        send_beat(d);
        d = '0;
        d[3*CB +: CB] = CB'(1); d[7*CB +: CB] = CB'(1); d[2*CB +: CB] = {CB{1'b1}};
        send_beat(d);
        d[8*CB +: CB] = {CB{1'b1}}; d[2*CB +: CB] = '0;
        send_beat(d);
        d = '0;
        d[0*CB +: CB] = pick_coord(0); d[3*CB +: CB] = pick_coord(1);
        d[7*CB +: CB] = pick_coord(1); d[4*CB +: CB] = CB'(1);
        d[5*CB +: CB] = {CB{1'b1}};
        send_beat(d);
        for (int i = 0; i < 8; i++) begin
            d = random_anchors();
            send_beat(d);
        end
        drain();

        // receiver held off while the sender keeps pushing
        hold_off = 1'b1;
        fork
            begin
                repeat (200) @(negedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 80; i++) send_beat(random_anchors());
        join
        drain();

        for (int i = 0; i < 320; ) begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst; j++, i++) send_beat(random_anchors());
            if ($urandom_range(0, 9) == 0)
                drain();
            else
                go_idle($urandom_range(0, 6));
        end
        drain();
        repeat (60) @(negedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
